// File: hdl/sliding_dft_tone_detector_defines.svh
// Assertion helpers for the sliding DFT tone detector.
`ifndef SLIDING_DFT_TONE_DETECTOR_DEFINES_SVH
`define SLIDING_DFT_TONE_DETECTOR_DEFINES_SVH
`ifndef SYNTH
`define SDTD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sdtd assertion failed");
`define SDTD_NEVER(label, cond) `SDTD_ASSERT(label, !(cond))
`else
`define SDTD_ASSERT(label, prop)
`define SDTD_NEVER(label, cond)
`endif
`endif

// File: hdl/sdtd_pkg.sv
package sdtd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 32;
  localparam int MAG_W      = 24;
  localparam int SEL_W      = 5;
  localparam int CFG_W      = 24;
  localparam int SQRT_STEPS = 24;
  localparam int FRAC_SHIFT = 14;

  localparam logic [SEL_W-1:0] SEL_RESET = 5'd10;
  localparam logic [MAG_W-1:0] THR_RESET = 24'd25600;

  localparam logic REG_SEL = 1'b0;
  localparam logic REG_THR = 1'b1;

  typedef struct packed {
    logic clr_run;
    logic smp_load;
    logic bin_run;
    logic mag_read;
    logic sq_re;
    logic sq_im;
    logic sqrt_start;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bins_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/sdtd_ctrl.sv
module sdtd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  sdtd_pkg::sts_t sts,
  output sdtd_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_BINS = 4'd2;
  localparam logic [3:0] ST_MRD  = 4'd3;
  localparam logic [3:0] ST_MSQR = 4'd4;
  localparam logic [3:0] ST_MSQI = 4'd5;
  localparam logic [3:0] ST_MSQS = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       last_q;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.smp_load = 1'b1;
          state_next   = ST_BINS;
        end
      end
      ST_BINS: begin
        cmd.bin_run = 1'b1;
        if (sts.bins_done) state_next = last_q ? ST_MRD : ST_IDLE;
      end
      ST_MRD: begin
        cmd.mag_read = 1'b1;
        state_next   = ST_MSQR;
      end
      ST_MSQR: begin
        cmd.sq_re  = 1'b1;
        state_next = ST_MSQI;
      end
      ST_MSQI: begin
        cmd.sq_im  = 1'b1;
        state_next = ST_MSQS;
      end
      ST_MSQS: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_SQRT;
      end
      ST_SQRT: begin
        if (sts.sqrt_done) state_next = ST_FIN;
        else cmd.sqrt_step = 1'b1;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLR;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.smp_load) last_q <= in_last;
    end
  end

`include "sliding_dft_tone_detector_defines.svh"
  `SDTD_ASSERT(a_emit_only_last, cmd.emit |-> last_q)
  `SDTD_ASSERT(a_load_then_bins, cmd.smp_load |=> (state == ST_BINS))
  `SDTD_ASSERT(a_sqrt_then_fin, (state == ST_SQRT) && sts.sqrt_done |=> (state == ST_FIN))
  `SDTD_NEVER(a_no_step_when_done, cmd.sqrt_step && sts.sqrt_done)

endmodule

// File: hdl/sdtd_datapath.sv
module sdtd_datapath #(
  parameter int POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sdtd_pkg::cmd_t                cmd,
  output sdtd_pkg::sts_t                sts,
  input  logic [sdtd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [sdtd_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdtd_pkg::MAG_W-1:0]    out_mag,
  output logic                          out_flag
);

  localparam int NBINS = POINTS / 2;
  localparam int PW    = $clog2(POINTS);
  localparam int BW    = $clog2(NBINS);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic logic [31:0] q30_to_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    return (v < 0) ? 32'd0 : 32'(r);
  endfunction

  function automatic logic [31:0] make_twiddle(input int unsigned n);
    logic        mirror;
    logic [63:0] num, x, x2, term;
    longint      s, c;
    logic [31:0] sq, cq;
    mirror = (4 * n > POINTS);
    num = mirror ? 64'(POINTS - 2 * n) : 64'(2 * n);
    x  = (PI_Q30 * num) / POINTS;
    x2 = (x * x) >> 30;
    s = longint'(x);
    term = x;
    term = ((term * x2) >> 30) / 6;   s = s - longint'(term);
    term = ((term * x2) >> 30) / 20;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 42;  s = s - longint'(term);
    term = ((term * x2) >> 30) / 72;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 110; s = s - longint'(term);
    term = ((term * x2) >> 30) / 156; s = s + longint'(term);
    term = ((term * x2) >> 30) / 210; s = s - longint'(term);
    term = ((term * x2) >> 30) / 272; s = s + longint'(term);
    c = longint'(64'd1 << 30);
    term = 64'd1 << 30;
    term = ((term * x2) >> 30) / 2;   c = c - longint'(term);
    term = ((term * x2) >> 30) / 12;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 30;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 56;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 90;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 132; c = c + longint'(term);
    term = ((term * x2) >> 30) / 182; c = c - longint'(term);
    term = ((term * x2) >> 30) / 240; c = c + longint'(term);
    sq = q30_to_q14(s);
    cq = q30_to_q14(c);
    if (mirror) cq = (32'h10000 - cq) & 32'hFFFF;
    return {cq[15:0], sq[15:0]};
  endfunction

  logic [31:0] tw_rom [NBINS];
  for (genvar g = 0; g < NBINS; g++) begin : g_tw
    localparam logic [31:0] TW = make_twiddle(g);
    assign tw_rom[g] = TW;
  end

  // configuration
  logic [sdtd_pkg::SEL_W-1:0] sel;
  logic [sdtd_pkg::MAG_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= sdtd_pkg::SEL_RESET;
      thr <= sdtd_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        sdtd_pkg::REG_SEL: sel <= cfg_data[sdtd_pkg::SEL_W-1:0];
        sdtd_pkg::REG_THR: thr <= cfg_data[sdtd_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic [PW:0] clr_cnt;
  logic        clr_done;
  assign clr_done = (clr_cnt == (PW+1)'(POINTS));

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_run && !clr_done) clr_cnt <= clr_cnt + 1'b1;
  end

  // history ring
  logic [sdtd_pkg::SAMPLE_W-1:0] hist [POINTS];
  logic [PW-1:0]                 pos;
  logic signed [15:0]            old_q;
  logic signed [15:0]            new_q;

  always_ff @(posedge clk) begin
    if (cmd.clr_run && !clr_done) begin
      hist[clr_cnt[PW-1:0]] <= '0;
    end else if (cmd.smp_load) begin
      hist[pos] <= sample;
    end
    if (cmd.smp_load) begin
      old_q <= hist[pos];
      new_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else if (cmd.smp_load) pos <= (pos == PW'(POINTS - 1)) ? '0 : pos + 1'b1;
  end

  // bin memory
  logic signed [31:0] bin_re [NBINS];
  logic signed [31:0] bin_im [NBINS];

  logic [BW:0]        issue_cnt;
  logic               issuing;
  logic [BW-1:0]      sel_idx;
  logic [BW-1:0]      rd_addr;
  logic signed [31:0] re_q, im_q;
  logic [31:0]        tw_q;
  logic [BW-1:0]      a_idx, b_idx, c_idx;
  logic               a_v, b_v, c_v;

  assign issuing = cmd.bin_run && (issue_cnt != (BW+1)'(NBINS));
  assign sel_idx = BW'(sel);
  assign rd_addr = issuing ? issue_cnt[BW-1:0] : sel_idx;

  always_ff @(posedge clk) begin
    if (rst) issue_cnt <= '0;
    else if (cmd.smp_load) issue_cnt <= '0;
    else if (issuing) issue_cnt <= issue_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (issuing || cmd.mag_read) begin
      re_q <= bin_re[rd_addr];
      im_q <= bin_im[rd_addr];
    end
    tw_q  <= tw_rom[rd_addr];
    a_idx <= rd_addr;
  end

  // stage B: fold in the sample difference
  logic signed [17:0] diff2;
  logic signed [33:0] tr_q;
  logic signed [31:0] ti_q;
  logic signed [15:0] cs_q, sn_q;

  assign diff2 = (18'(new_q) - 18'(old_q)) <<< 1;

  always_ff @(posedge clk) begin
    tr_q  <= 34'(re_q) + 34'(diff2);
    ti_q  <= im_q;
    cs_q  <= tw_q[31:16];
    sn_q  <= tw_q[15:0];
    b_idx <= a_idx;
  end

  // stage C: rotate
  logic signed [49:0] p_rc, p_is, p_rs, p_ic;

  always_ff @(posedge clk) begin
    p_rc  <= tr_q * cs_q;
    p_is  <= ti_q * sn_q;
    p_rs  <= tr_q * sn_q;
    p_ic  <= ti_q * cs_q;
    c_idx <= b_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      a_v <= issuing;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  function automatic logic signed [31:0] round_sat(input logic signed [50:0] acc);
    logic signed [36:0] sh;
    sh = acc[50:sdtd_pkg::FRAC_SHIFT];
    if (sh > 37'sd2147483647) return 32'sh7FFFFFFF;
    else if (sh < -37'sd2147483648) return 32'sh80000000;
    else return sh[31:0];
  endfunction

  logic signed [50:0] acc_re, acc_im;
  logic               bwe;
  logic [BW-1:0]      waddr;
  logic signed [31:0] wre, wim;

  assign acc_re = 51'(p_rc) - 51'(p_is) + 51'sd8192;
  assign acc_im = 51'(p_rs) + 51'(p_ic) + 51'sd8192;

  always_comb begin
    if (cmd.clr_run) begin
      bwe   = !clr_done && (clr_cnt < (PW+1)'(NBINS));
      waddr = clr_cnt[BW-1:0];
      wre   = '0;
      wim   = '0;
    end else begin
      bwe   = c_v;
      waddr = c_idx;
      wre   = round_sat(acc_re);
      wim   = round_sat(acc_im);
    end
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      bin_re[waddr] <= wre;
      bin_im[waddr] <= wim;
    end
  end

  // magnitude
  logic        rng_q;
  logic [31:0] sq_op;
  logic [63:0] sq_q, sum_q;
  logic [47:0] rem, res, bitv;
  logic [4:0]  sq_cnt;
  logic [47:0] trial;

  assign sq_op = cmd.sq_re ? (re_q[31] ? 32'(-re_q) : 32'(re_q))
                           : (im_q[31] ? 32'(-im_q) : 32'(im_q));
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (cmd.mag_read) rng_q <= (32'(sel) < 32'(NBINS));
    if (cmd.sq_re) sq_q <= sq_op * sq_op;
    if (cmd.sq_im) sum_q <= sq_q + sq_op * sq_op;
    if (cmd.sqrt_start) begin
      rem  <= rng_q ? sum_q[63:16] : '0;
      res  <= '0;
      bitv <= 48'd1 << 46;
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sq_cnt <= '0;
    else if (cmd.sqrt_start) sq_cnt <= '0;
    else if (cmd.sqrt_step) sq_cnt <= sq_cnt + 1'b1;
  end

  // output register
  logic [26:0] mag5;
  logic [23:0] mag_sat;

  assign mag5    = (27'(res[23:0]) << 2) + 27'(res[23:0]);
  assign mag_sat = (mag5 > 27'hFFFFFF) ? 24'hFFFFFF : mag5[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_mag  <= mag_sat;
      out_flag <= (mag_sat > thr);
    end
  end

  assign sts.clr_done  = clr_done;
  assign sts.bins_done = (issue_cnt == (BW+1)'(NBINS)) && !a_v && !b_v && !c_v;
  assign sts.sqrt_done = (sq_cnt == 5'(sdtd_pkg::SQRT_STEPS));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// File: hdl/sliding_dft_tone_detector.sv
// Sliding DFT tone detector. Each sample transaction replaces the oldest of
// the last POINTS samples and updates all POINTS/2 bins through one pipelined
// twiddle-rotate lane, one bin per cycle; s_tready stays low until all bins
// are written. A sample marked tlast then takes the selected bin's magnitude
// (squares of both parts and a 24-step square root) before the result appears
// on the master side. After reset a clearing pass zeroes the sample ring and
// bins; s_tready stays low until it ends.
module sliding_dft_tone_detector #(
  parameter int POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample_value
  input  logic        s_tlast,   // last_of_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // magnitude_scaled
  output logic        m_tuser,   // carrier_present
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_data
);

  sdtd_pkg::cmd_t cmd;
  sdtd_pkg::sts_t sts;

  sdtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdtd_datapath #(
    .POINTS (POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mag   (m_tdata),
    .out_flag  (m_tuser)
  );

endmodule

// File: bench/sliding_dft_tone_detector_checker.sv
module sliding_dft_tone_detector_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [15:0]       s_tdata,   // sample_value
  input  logic              s_tlast,   // last_of_block
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,   // magnitude_scaled
  input  logic              m_tuser,   // carrier_present
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [23:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam int NPTS = 64;
  localparam int NBINS = NPTS / 2;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint BIN_MAX = 64'sd2147483647;
  localparam longint BIN_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [sdtd_pkg::MAG_W-1:0] magnitude;
    logic                       carrier;
  } tone_result_t;

  logic [15:0]                sample_ring [NPTS];
  int                         ring_pos;
  longint                     acc_re [NBINS];
  longint                     acc_im [NBINS];
  logic [31:0]                rotor [NBINS];
  logic [sdtd_pkg::SEL_W-1:0] watch_bin;
  logic [sdtd_pkg::MAG_W-1:0] threshold;
  tone_result_t               tone_queue [$];

  function automatic longint q30_to_q14(longint v);
    if (v < 0) return 0;
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] rotor_word(int n);
    longint unsigned num, x, x2, term;
    longint s, c;
    logic [15:0] cq, sq;
    bit mirror;
    mirror = (4 * n > NPTS);
    num = mirror ? longint'(NPTS - 2 * n) : longint'(2 * n);
    x = (PI_Q30 * num) / NPTS;
    x2 = (x * x) >> 30;
    s = longint'(x);
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      s = (k & 1) ? s - longint'(term) : s + longint'(term);
    end
    c = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      c = (k & 1) ? c - longint'(term) : c + longint'(term);
    end
    sq = 16'(q30_to_q14(s));
    cq = 16'(q30_to_q14(c));
    if (mirror) cq = 16'h0000 - cq;
    return {cq, sq};
  endfunction

  function automatic longint clamp32(longint v);
    if (v > BIN_MAX) return BIN_MAX;
    if (v < BIN_MIN) return BIN_MIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // slide one sample through every bin, queue the tone result if requested
  task automatic slide_sample(input logic [15:0] smp, input logic last);
    longint new_s, old_s, tr, ti, cs, sn, re, im;
    longint unsigned sum, mag;
    tone_result_t res;
    new_s = longint'($signed(smp)) * 2;
    old_s = longint'($signed(sample_ring[ring_pos])) * 2;
    sample_ring[ring_pos] = smp;
    for (int n = 0; n < NBINS; n++) begin
      cs = longint'($signed(rotor[n][31:16]));
      sn = longint'($signed(rotor[n][15:0]));
      tr = acc_re[n] - old_s + new_s;
      ti = acc_im[n];
      acc_re[n] = clamp32((tr * cs - ti * sn + 8192) >>> 14);
      acc_im[n] = clamp32((tr * sn + ti * cs + 8192) >>> 14);
    end
    ring_pos = (ring_pos + 1) % NPTS;
    if (last) begin
      mag = 0;
      if (watch_bin < NBINS) begin
        re = acc_re[watch_bin];
        im = acc_im[watch_bin];
        sum = longint'(re * re) + longint'(im * im);
        mag = int_sqrt(sum >> 16) * 5;
        if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
      end
      res.magnitude = mag[sdtd_pkg::MAG_W-1:0];
      res.carrier = (mag > longint'(threshold));
      tone_queue.push_back(res);
    end
  endtask

  initial begin
    fail_count = 0;
    for (int n = 0; n < NBINS; n++) rotor[n] = rotor_word(n);
  end

  assign pending = tone_queue.size();

  always @(posedge clk) begin
    tone_result_t exp_r;
    if (rst) begin
      for (int n = 0; n < NPTS; n++) sample_ring[n] = '0;
      for (int n = 0; n < NBINS; n++) begin
        acc_re[n] = 0;
        acc_im[n] = 0;
      end
      ring_pos = 0;
      watch_bin = sdtd_pkg::SEL_RESET;
      threshold = sdtd_pkg::THR_RESET;
      tone_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == sdtd_pkg::REG_SEL) watch_bin = cfg_data[sdtd_pkg::SEL_W-1:0];
        else if (cfg_addr == sdtd_pkg::REG_THR) threshold = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (tone_queue.size() == 0) begin
          $display("%0t: unexpected result mag=%0d flag=%0b", $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          exp_r = tone_queue.pop_front();
          if (m_tdata !== exp_r.magnitude) begin
            $display("%0t: magnitude expected %0d actual %0d", $time, exp_r.magnitude,
                     m_tdata);
            fail_count++;
          end
          if (m_tuser !== exp_r.carrier) begin
            $display("%0t: carrier flag expected %0b actual %0b", $time, exp_r.carrier,
                     m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) slide_sample(s_tdata, s_tlast);
    end
  end

endmodule

// File: bench/sliding_dft_tone_detector_test.sv
module sliding_dft_tone_detector_test;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample_value
  logic        s_tlast;   // last_of_block
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // magnitude_scaled
  logic        m_tuser;   // carrier_present
  logic        cfg_we;
  logic        cfg_addr;
  logic [23:0] cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int gap_pct;
  int stall_pct;
  bit hold_off;
  bit hold_req;

  sliding_dft_tone_detector u_dut (.*);

  sliding_dft_tone_detector_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready = !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 1'b0;
    wait (hold_req);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (600) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic send_sample(input logic [15:0] v, input logic last);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = v;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // blocks of random length: noise, tones, extremes
  task automatic run_blocks(input int count);
    int sent, len, kind, amp;
    logic [15:0] v;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 130) : $urandom_range(1, 40);
      kind = $urandom_range(4);
      amp = $urandom_range(32767);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: v = 16'($urandom);
          1: v = (i % 4 == 0) ? 16'(amp) : (i % 4 == 2) ? 16'(-amp) : 16'h0000;
          2: v = (i % 2 == 0) ? 16'(amp) : 16'(-amp);
          3: v = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
          default: v = 16'($urandom_range(2047)) - 16'd1024;
        endcase
        send_sample(v, (i == len - 1) || ($urandom_range(49) == 0));
      end
      sent += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = sdtd_pkg::REG_SEL;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    cycles = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    for (int i = 0; i < 16; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 15);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    drain();

    write_reg(sdtd_pkg::REG_SEL, 24'd0);
    write_reg(sdtd_pkg::REG_THR, 24'd0);
    run_blocks(500);
    drain();

    write_reg(sdtd_pkg::REG_SEL, 24'd16);
    write_reg(sdtd_pkg::REG_THR, 24'd20000);
    gap_pct = 54;
    hold_req = 1'b1;
    run_blocks(500);
    drain();

    write_reg(sdtd_pkg::REG_SEL, 24'd31);
    write_reg(sdtd_pkg::REG_THR, 24'hFFFFFF);
    gap_pct = 0;
    stall_pct = 54;
    run_blocks(500);
    drain();

    write_reg(sdtd_pkg::REG_SEL, 24'd10);
    write_reg(sdtd_pkg::REG_THR, 24'd25600);
    gap_pct = 28;
    stall_pct = 28;
    run_blocks(250);
    drain();
    write_reg(sdtd_pkg::REG_SEL, 24'($urandom_range(31)));
    write_reg(sdtd_pkg::REG_THR, 24'($urandom_range(60000)));
    run_blocks(250);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sliding_dft_tone_detector.f
+incdir+hdl
hdl/sdtd_pkg.sv
hdl/sdtd_ctrl.sv
hdl/sdtd_datapath.sv
hdl/sliding_dft_tone_detector.sv
bench/sliding_dft_tone_detector_checker.sv
bench/sliding_dft_tone_detector_test.sv
